/* rtl/ssc_pkg.sv */
// shared types and constants for the shortest common supersequence counter
package ssc_pkg;

  // field widths fixed by the interface
  localparam int ACT_W  = 2;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 7;
  localparam int CNT_W  = 61;

  // action codes
  localparam logic [ACT_W-1:0] ACT_APPEND_A = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND_B = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE  = 2'd2;

  // one entry of the dynamic programming table
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] cnt;
  } cell_t;

endpackage

/* rtl/ssc_cell.sv */
// shared table cell unit: compare, increment and count merge
module ssc_cell (
  input  logic          match,
  input  ssc_pkg::cell_t diag,
  input  ssc_pkg::cell_t down,
  input  ssc_pkg::cell_t right,
  output ssc_pkg::cell_t result
);
  import ssc_pkg::*;

  // take the diagonal on a match, else the shorter neighbor, or both on a tie
  always_comb begin
    if (match) begin
      result.len = diag.len + LEN_W'(1);
      result.cnt = diag.cnt;
    end else if (down.len < right.len) begin
      result.len = down.len + LEN_W'(1);
      result.cnt = down.cnt;
    end else if (right.len < down.len) begin
      result.len = right.len + LEN_W'(1);
      result.cnt = right.cnt;
    end else begin
      result.len = down.len + LEN_W'(1);
      result.cnt = down.cnt + right.cnt;
    end
  end

endmodule

/* rtl/ssc_str_mem.sv */
// byte string storage with one write port and a registered read port
module ssc_str_mem #(
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [ssc_pkg::CHAR_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [ssc_pkg::CHAR_W-1:0] rdata
);
  import ssc_pkg::*;

  logic [CHAR_W-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ssc_row_mem.sv */
// one row of the table: single write port, registered read (old data on collision)
module ssc_row_mem #(
  parameter int DEPTH = 33,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  ssc_pkg::cell_t wdata,
  input  logic [AW-1:0]  raddr,
  output ssc_pkg::cell_t rdata
);
  import ssc_pkg::*;

  cell_t mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/shortest_supersequence_count.sv */
// top level: string loading, table sequencer and result register
//
//  channel  signals                                       direction
//  item     item_valid, item_stall, action, char_in      into the block
//  result   result_valid, result_stall, super_length,
//           super_count, overflow_flag                    out of the block
//
// an append goes into its string store without stalling. a compute with
// string A empty goes straight to the final state; else it fills the row
// memory (m+1 entries), then per row of A writes the boundary entry and,
// when m is nonzero, fetches the A byte and the diagonal seed, then walks the cells through the single cell unit.
// reset is synchronous; it empties both strings and clears the drop flag.
// item_stall is high while a compute runs, and its last cycle stretches while
// an earlier result still waits under result_stall; a finished result waits
// in the output register while appends are taken.
module shortest_supersequence_count #(
  parameter int MAX_LEN = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [ssc_pkg::ACT_W-1:0]  action,
  input  logic [ssc_pkg::CHAR_W-1:0] char_in,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [ssc_pkg::LEN_W-1:0]  super_length,
  output logic [ssc_pkg::CNT_W-1:0]  super_count,
  output logic                       overflow_flag
);
  import ssc_pkg::*;

  localparam int SAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int RIW = $clog2(MAX_LEN + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_ROW0 = 3'd2;
  localparam logic [2:0] S_ROW1 = 3'd3;
  localparam logic [2:0] S_CELL = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        state;
  logic [RIW-1:0]    len_a;
  logic [RIW-1:0]    len_b;
  logic              dropped;
  logic [RIW-1:0]    n;
  logic [RIW-1:0]    m;
  logic              flag;
  logic [RIW-1:0]    ii;
  logic [RIW-1:0]    jj;
  logic [CHAR_W-1:0] achar;
  cell_t             diag;
  cell_t             right;

  logic              accept;
  logic              a_we;
  logic              b_we;
  logic [SAW-1:0]    b_raddr;
  logic [CHAR_W-1:0] a_rdata;
  logic [CHAR_W-1:0] b_rdata;
  logic              row_we;
  logic [RIW-1:0]    row_waddr;
  logic [RIW-1:0]    row_raddr;
  cell_t             row_wdata;
  cell_t             row_rdata;
  cell_t             cell_new;
  cell_t             edge_cell;
  logic              out_free;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  // string stores
  assign a_we = accept && (action == ACT_APPEND_A) && (len_a < RIW'(MAX_LEN));
  assign b_we = accept && (action == ACT_APPEND_B) && (len_b < RIW'(MAX_LEN));

  ssc_str_mem #(.DEPTH(MAX_LEN)) u_str_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (len_a[SAW-1:0]),
    .wdata (char_in),
    .raddr (ii[SAW-1:0]),
    .rdata (a_rdata)
  );

  ssc_str_mem #(.DEPTH(MAX_LEN)) u_str_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (len_b[SAW-1:0]),
    .wdata (char_in),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // shared cell unit
  ssc_cell u_cell (
    .match  (achar == b_rdata),
    .diag   (diag),
    .down   (row_rdata),
    .right  (right),
    .result (cell_new)
  );

  ssc_row_mem #(.DEPTH(MAX_LEN + 1)) u_row (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // boundary entry of the current row: length n-i, one way
  assign edge_cell.len = LEN_W'(n - ii);
  assign edge_cell.cnt = CNT_W'(1);

  // row memory port steering
  always_comb begin
    row_we          = 1'b0;
    row_waddr       = jj;
    row_wdata       = cell_new;
    row_raddr       = m;
    b_raddr         = jj[SAW-1:0];
    case (state)
      S_INIT: begin
        row_we        = 1'b1;
        row_wdata.len = LEN_W'(m - jj);
        row_wdata.cnt = CNT_W'(1);
      end
      S_ROW0: begin
        row_we    = 1'b1;
        row_waddr = m;
        row_wdata = edge_cell;
      end
      S_ROW1: begin
        row_raddr = m - RIW'(1);
        b_raddr   = SAW'(m - RIW'(1));
      end
      S_CELL: begin
        row_we    = 1'b1;
        row_raddr = jj - RIW'(1);
        b_raddr   = SAW'(jj - RIW'(1));
      end
      default: begin
        row_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      len_a   <= '0;
      len_b   <= '0;
      dropped <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action)
              ACT_APPEND_A: begin
                if (a_we) len_a <= len_a + RIW'(1);
                else dropped <= 1'b1;
              end
              ACT_APPEND_B: begin
                if (b_we) len_b <= len_b + RIW'(1);
                else dropped <= 1'b1;
              end
              ACT_COMPUTE: begin
                n       <= len_a;
                m       <= len_b;
                flag    <= dropped;
                len_a   <= '0;
                len_b   <= '0;
                dropped <= 1'b0;
                jj      <= '0;
                if (len_a == '0) begin
                  right.len <= LEN_W'(len_b);
                  right.cnt <= CNT_W'(1);
                  state     <= S_DONE;
                end else begin
                  state <= S_INIT;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_INIT: begin
          jj <= jj + RIW'(1);
          if (jj == m) begin
            ii    <= n - RIW'(1);
            state <= S_ROW0;
          end
        end
        S_ROW0: begin
          right <= edge_cell;
          if (m == '0) begin
            if (ii == '0) begin
              state <= S_DONE;
            end else begin
              ii    <= ii - RIW'(1);
              state <= S_ROW0;
            end
          end else begin
            state <= S_ROW1;
          end
        end
        S_ROW1: begin
          diag  <= row_rdata;
          achar <= a_rdata;
          jj    <= m - RIW'(1);
          state <= S_CELL;
        end
        S_CELL: begin
          right <= cell_new;
          diag  <= row_rdata;
          if (jj != '0) begin
            jj <= jj - RIW'(1);
          end else if (ii == '0) begin
            state <= S_DONE;
          end else begin
            ii    <= ii - RIW'(1);
            state <= S_ROW0;
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      super_length  <= right.len;
      super_count   <= right.cnt;
      overflow_flag <= flag;
    end
  end

  // a new result only comes out of the final state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside final state");

  // there is always at least one shortest supersequence
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> super_count != '0)
    else $error("zero supersequence count");

  // length bounded by both strings full
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> super_length <= LEN_W'(2 * MAX_LEN))
    else $error("supersequence length out of range");

  // cell column stays inside the B string
  a_column_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CELL |-> jj < m)
    else $error("cell column beyond string B");

endmodule

/* test/tb_shortest_supersequence_count.sv */
// testbench for the shortest common supersequence length and count block
`timescale 1ns / 1ps

module tb_shortest_supersequence_count;
  import ssc_pkg::*;

  localparam int MAX_LEN = 32;
  localparam int RANDOM_ITEMS = 1600;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int DRAIN_CYCLES = 1200;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [CHAR_W-1:0] ch;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [ACT_W-1:0] action = '0;
  logic [CHAR_W-1:0] char_in = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [LEN_W-1:0] super_length;
  logic [CNT_W-1:0] super_count;
  logic overflow_flag;

  // pending stimulus and predicted answers
  item_t action_queue[$];
  answer_t expected_answers[$];

  // mirror of the string store
  logic [CHAR_W-1:0] str_a [0:MAX_LEN-1];
  logic [CHAR_W-1:0] str_b [0:MAX_LEN-1];
  int len_a = 0;
  int len_b = 0;
  logic drop_seen = 1'b0;

  int shown_cnt = 0;
  int taken_cnt = 0;
  int queued_cnt = 0;
  int real_items = 0;
  int job_cnt = 0;
  int results_seen = 0;
  int drop_results = 0;
  int longest_seen = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_run = 0;

  shortest_supersequence_count #(.MAX_LEN(MAX_LEN)) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .char_in      (char_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .super_length (super_length),
    .super_count  (super_count),
    .overflow_flag(overflow_flag)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // suffix table over the mirrored strings, one row kept at a time
  function automatic answer_t scs_solve();
    logic [LEN_W-1:0] lrow [0:MAX_LEN];
    logic [CNT_W-1:0] crow [0:MAX_LEN];
    logic [LEN_W-1:0] diag_l, down_l, right_l, new_l;
    logic [CNT_W-1:0] diag_c, down_c, right_c, new_c;
    answer_t r;
    int i, j;
    for (j = 0; j <= len_b; j++) begin
      lrow[j] = LEN_W'(len_b - j);
      crow[j] = CNT_W'(1);
    end
    for (i = len_a - 1; i >= 0; i--) begin
      diag_l = lrow[len_b];
      diag_c = crow[len_b];
      lrow[len_b] = LEN_W'(len_a - i);
      crow[len_b] = CNT_W'(1);
      for (j = len_b - 1; j >= 0; j--) begin
        down_l = lrow[j];
        down_c = crow[j];
        right_l = lrow[j+1];
        right_c = crow[j+1];
        if (str_a[i] == str_b[j]) begin
          new_l = diag_l + 1'b1;
          new_c = diag_c;
        end else if (down_l < right_l) begin
          new_l = down_l + 1'b1;
          new_c = down_c;
        end else if (right_l < down_l) begin
          new_l = right_l + 1'b1;
          new_c = right_c;
        end else begin
          new_l = down_l + 1'b1;
          new_c = down_c + right_c;
        end
        diag_l = down_l;
        diag_c = down_c;
        lrow[j] = new_l;
        crow[j] = new_c;
      end
    end
    r.len = lrow[0];
    r.cnt = crow[0];
    r.ovf = drop_seen;
    return r;
  endfunction

  // apply one accepted transaction to the mirrored state
  task automatic apply_item(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] ch);
    case (act)
      ACT_APPEND_A: begin
        if (len_a < MAX_LEN) begin
          str_a[len_a] = ch;
          len_a++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      ACT_APPEND_B: begin
        if (len_b < MAX_LEN) begin
          str_b[len_b] = ch;
          len_b++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      ACT_COMPUTE: begin
        expected_answers.push_back(scs_solve());
        len_a = 0;
        len_b = 0;
        drop_seen = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic add_item(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] ch);
    item_t it;
    it.act = act;
    it.ch = ch;
    action_queue.push_back(it);
    queued_cnt++;
    if (act != ACT_UNUSED) real_items++;
    if (act == ACT_COMPUTE) job_cnt++;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 10);
    if (r < 90) return $urandom_range(11, 24);
    return $urandom_range(25, MAX_LEN);
  endfunction

  // one job: interleaved loads with some noise, optional dropped loads, compute
  task automatic make_job(input int na, input int nb, input int extra);
    int ia, ib, k, base, span;
    case ($urandom_range(0, 3))
      0: span = 2;
      1: span = 3;
      2: span = 4;
      default: span = 256;
    endcase
    base = (span == 256) ? 0 : $urandom_range(0, 256 - span);
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if ($urandom_range(0, 24) == 0) add_item(ACT_UNUSED, CHAR_W'($urandom_range(0, 255)));
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
        add_item(ACT_APPEND_A, CHAR_W'(base + $urandom_range(0, span - 1)));
        ia++;
      end else begin
        add_item(ACT_APPEND_B, CHAR_W'(base + $urandom_range(0, span - 1)));
        ib++;
      end
    end
    for (k = 0; k < extra; k++) begin
      if (na == MAX_LEN && (nb != MAX_LEN || $urandom_range(0, 1) == 1))
        add_item(ACT_APPEND_A, CHAR_W'($urandom_range(0, 255)));
      else
        add_item(ACT_APPEND_B, CHAR_W'($urandom_range(0, 255)));
    end
    add_item(ACT_COMPUTE, CHAR_W'($urandom_range(0, 255)));
  endtask

  // item driver: bursts of transactions separated by random gaps
  always @(negedge clk) begin : drive_items
    item_t nxt;
    if (!rst) begin
      if (!item_valid || taken_cnt == shown_cnt) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (action_queue.size() > 0) begin
          nxt = action_queue.pop_front();
          item_valid <= 1'b1;
          action <= nxt.act;
          char_in <= nxt.ch;
          shown_cnt++;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 7))
              0, 1: gap_left = 0;
              2: gap_left = $urandom_range(10, 30);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result stall pattern: quiet stretches and short random runs
  always @(negedge clk) begin : drive_stall
    if (stall_run > 0) begin
      stall_run--;
    end else if ($urandom_range(0, 5) == 0) begin
      result_stall <= 1'b0;
      stall_run = $urandom_range(20, 150);
    end else begin
      result_stall <= 1'($urandom_range(0, 1));
      stall_run = $urandom_range(0, 11);
    end
  end

  // monitor: check results, update the mirror on accepted items, watchdog
  always @(posedge clk) begin : watch_outputs
    answer_t want;
    logic moved;
    if (!rst) begin
      moved = 1'b0;
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        results_seen++;
        if (expected_answers.size() == 0) begin
          $error("result transaction with no compute pending: length %0d count %0d flag %0d",
                 super_length, super_count, overflow_flag);
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          if (want.ovf) drop_results++;
          if (int'(want.len) > longest_seen) longest_seen = want.len;
          if (super_length !== want.len) begin
            $error("super_length mismatch: expected %0d, actual %0d", want.len, super_length);
            fail_count++;
          end
          if (super_count !== want.cnt) begin
            $error("super_count mismatch: expected %0d, actual %0d", want.cnt, super_count);
            fail_count++;
          end
          if (overflow_flag !== want.ovf) begin
            $error("overflow_flag mismatch: expected %0d, actual %0d", want.ovf, overflow_flag);
            fail_count++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        moved = 1'b1;
        taken_cnt++;
        apply_item(action, char_in);
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles", idle_cycles);
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin : run_test
    int k, na, nb, extra;

    // directed: empty strings, single bytes, byte extremes, ignored code
    add_item(ACT_COMPUTE, 8'h00);
    add_item(ACT_APPEND_A, 8'h00);
    add_item(ACT_COMPUTE, 8'hFF);
    add_item(ACT_APPEND_B, 8'hFF);
    add_item(ACT_COMPUTE, 8'h00);
    add_item(ACT_APPEND_A, 8'h00);
    add_item(ACT_APPEND_A, 8'hFF);
    add_item(ACT_APPEND_B, 8'hFF);
    add_item(ACT_APPEND_B, 8'h00);
    add_item(ACT_COMPUTE, 8'hFF);
    add_item(ACT_APPEND_A, 8'h5A);
    add_item(ACT_APPEND_B, 8'h5A);
    add_item(ACT_UNUSED, 8'hA5);
    add_item(ACT_APPEND_A, 8'h3C);
    add_item(ACT_APPEND_B, 8'h3C);
    add_item(ACT_COMPUTE, 8'h00);
    add_item(ACT_UNUSED, 8'h00);
    add_item(ACT_UNUSED, 8'hFF);
    add_item(ACT_COMPUTE, 8'hAA);

    // both strings full and disjoint, plus a dropped load on each
    for (k = 0; k < MAX_LEN; k++) add_item(ACT_APPEND_A, 8'h00);
    for (k = 0; k < MAX_LEN; k++) add_item(ACT_APPEND_B, 8'hFF);
    add_item(ACT_APPEND_A, 8'h11);
    add_item(ACT_APPEND_B, 8'h22);
    add_item(ACT_COMPUTE, 8'h00);

    // random jobs, a few pushed past the string size
    k = real_items;
    while (real_items < k + RANDOM_ITEMS) begin
      na = pick_len();
      nb = pick_len();
      extra = 0;
      if ($urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 1) == 1) na = MAX_LEN;
        else nb = MAX_LEN;
        extra = $urandom_range(1, 3);
      end
      make_job(na, nb, extra);
    end

    // reset
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // drain
    while (taken_cnt < queued_cnt) @(posedge clk);
    while (expected_answers.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d transactions in %0d jobs; %0d results checked", taken_cnt, job_cnt,
             results_seen);
    $display("%0d results flagged dropped loads, longest supersequence %0d", drop_results,
             longest_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
